// ----- design/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants, beat types and helpers for the calibration region tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int unsigned SLICES    = 16;
  localparam int unsigned LINES     = 256;
  localparam int unsigned WORDS     = (LINES + 63) / 64;
  localparam int unsigned LINE_W    = $clog2(LINES);
  localparam int unsigned WORD_W    = (LINE_W > 6) ? LINE_W - 6 : 1;
  localparam int unsigned SLICE_W   = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int unsigned ADDR_W    = SLICE_W + WORD_W;
  localparam int unsigned MEM_DEPTH = SLICES << WORD_W;
  // run bounds: wide enough for any line and for the 8-bit centre line
  localparam int unsigned BND_W     = (LINE_W > 8) ? LINE_W : 8;
  localparam int unsigned PADDR_W   = 4;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_CENTER    = 2'd0,
    REG_OFFSET    = 2'd1,
    REG_MIN_WIDTH = 2'd2,
    REG_SAMPLES   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [3:0]  slice_index;
    logic [15:0] line_index;
    logic [15:0] partition_index;
  } in_item_t;

  typedef struct packed {
    logic        error_flag;
    logic        slice_present;
    logic [7:0]  region_low;
    logic [7:0]  region_high;
    logic        sufficient;
    logic [15:0] support_low;
    logic [15:0] support_high;
    logic [15:0] support_samples;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        center_line;
    logic signed [8:0] row_offset;
    logic [7:0]        min_calib_width;
    logic [15:0]       samples_per_line;
  } cfg_t;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [63:0]        wr_data;
    logic               clr_en;
    logic [SLICE_W-1:0] clr_slice;
  } map_req_t;

  // index of the highest set bit (0 when none)
  function automatic logic [5:0] msb_idx(input logic [63:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // index of the lowest set bit (0 when none)
  function automatic logic [5:0] lsb_idx(input logic [63:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ----- design/calibration_region_tracker.sv -----
// ----------------------------------------------------------------------------
// calibration_region_tracker
// Per-slice map of received k-space lines and the sampled run around centre.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_data_i): one beat per acquisition
// line, either adding its line to the slice map or clearing the slice.
// Output channel (out_valid_o/out_ready_i, out_data_o): exactly one beat per
// input beat, in order, with the error flag, the contiguous run around the
// centre line, the sufficiency flag and the region of support.
// The map lives in one 64-bit wide memory, one word per 64 lines of a slice;
// the run is found by walking words down then up from the centre word, one
// word per cycle through the single read port, visiting 2 to 5 words at 256
// lines. An add first updates its map word by read-modify-write. One item is
// in flight at a time, so a new item is taken only once the last result has
// entered the output register.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a finished result is held until the register frees.
// Reset empties all slice maps at once (per-word valid bits) and loads the
// register defaults; no clearing pass is needed. Registers sit on the APB port.
// ----------------------------------------------------------------------------
module calibration_region_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  crt_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output crt_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import crt_pkg::*;

  cfg_t        cfg;
  map_req_t    map_req;
  logic [63:0] map_rd_data;

  crt_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crt_map_store u_map_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (map_rd_data)
  );

  crt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .map_req_o     (map_req),
    .map_rd_data_i (map_rd_data)
  );

endmodule

// ----- design/crt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// crt_cfg_regs
// APB register file: centre line, line offset, minimum width, samples/line.
// ----------------------------------------------------------------------------
module crt_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crt_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output crt_pkg::cfg_t                cfg_o
);
  import crt_pkg::*;

  cfg_t       cfg_q;
  reg_idx_e   reg_idx;
  logic       wr_beat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_beat = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_line      <= 8'd128;
      cfg_q.row_offset       <= 9'sd0;
      cfg_q.min_calib_width  <= 8'd24;
      cfg_q.samples_per_line <= 16'd256;
    end else if (wr_beat) begin
      case (reg_idx)
        REG_CENTER:    cfg_q.center_line      <= pwdata[7:0];
        REG_OFFSET:    cfg_q.row_offset       <= pwdata[8:0];
        REG_MIN_WIDTH: cfg_q.min_calib_width  <= pwdata[7:0];
        REG_SAMPLES:   cfg_q.samples_per_line <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER:    prdata = {24'd0, cfg_q.center_line};
      REG_OFFSET:    prdata = {23'd0, cfg_q.row_offset};
      REG_MIN_WIDTH: prdata = {24'd0, cfg_q.min_calib_width};
      REG_SAMPLES:   prdata = {16'd0, cfg_q.samples_per_line};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- design/crt_map_store.sv -----
// ----------------------------------------------------------------------------
// crt_map_store
// Line map memory, one 64-bit word per slice and word index, with per-entry
// valid bits so that reset and slice clears take effect at once.
// ----------------------------------------------------------------------------
module crt_map_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crt_pkg::map_req_t req_i,
  output logic [63:0]       rd_data_o
);
  import crt_pkg::*;

  logic [63:0]          mem [MEM_DEPTH];
  logic [63:0]          rd_data_q;
  logic [MEM_DEPTH-1:0] vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
      for (int i = 0; i < MEM_DEPTH; i++) begin
        if (req_i.clr_en && ((ADDR_W'(i) >> WORD_W) == ADDR_W'(req_i.clr_slice))) begin
          vld_q[i] <= 1'b0;
        end
      end
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  // an entry never written since its last clear reads as empty
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

  a_no_wr_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.wr_en && req_i.clr_en))
    else $error("map write and slice clear in the same cycle");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en && (req_i.rd_addr == req_i.wr_addr)))
    else $error("read and write of one entry in the same cycle");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.rd_en && !vld_q[req_i.rd_addr]) |=> (rd_data_o == '0))
    else $error("unwritten entry read back nonzero");

endmodule

// ----- design/crt_seq.sv -----
// ----------------------------------------------------------------------------
// crt_seq
// Item sequencer: map update by read-modify-write, then a word-serial walk
// down and up from the centre line, result register towards the output.
// ----------------------------------------------------------------------------
module crt_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crt_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crt_pkg::out_item_t out_data_o,
  output crt_pkg::map_req_t  map_req_o,
  input  logic [63:0]        map_rd_data_i
);
  import crt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_LO_RD,
    ST_LO_EV,
    ST_HI_RD,
    ST_HI_EV,
    ST_RESULT
  } state_e;

  state_e             state_q;
  logic [SLICE_W-1:0] slice_q;
  logic               bad_slice_q;
  logic               err_q;
  logic [5:0]         bitpos_q;
  logic [WORD_W-1:0]  lw_q;
  logic [WORD_W-1:0]  w_q;
  logic               full_q;
  logic [BND_W-1:0]   lo_q;
  logic [BND_W-1:0]   hi_q;
  logic [SLICES-1:0]  slice_valid_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               accept;
  logic               bad_slice;
  logic               bad_add;
  logic               add_ok;
  logic               clr_ok;
  logic [SLICE_W-1:0] in_slice;
  logic [BND_W-1:0]   cen_ext;
  logic [WORD_W-1:0]  cw;
  logic               cen_out;
  logic [63:0]        word;
  logic [63:0]        lo_zeros;
  logic [63:0]        hi_zeros;
  logic [BND_W-1:0]   base;
  logic [BND_W-1:0]   lo_found;
  logic [BND_W-1:0]   hi_found;
  logic [BND_W-1:0]   hi_end;
  logic               out_load;
  logic [15:0]        off16;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_slice  = in_data_i.slice_index[SLICE_W-1:0];
  assign bad_slice = (32'(in_data_i.slice_index) >= SLICES);
  assign bad_add   = (in_data_i.partition_index != '0) || (32'(in_data_i.line_index) >= LINES);
  assign add_ok    = !bad_slice && (in_data_i.opcode == OP_ADD) && !bad_add;
  assign clr_ok    = !bad_slice && (in_data_i.opcode == OP_CLEAR);

  assign cen_ext = BND_W'(cfg_i.center_line);
  assign cw      = cen_ext[6 +: WORD_W];
  assign cen_out = (32'(cfg_i.center_line) >= LINES);

  // an out-of-range slice looks like an empty map
  assign word     = bad_slice_q ? '0 : map_rd_data_i;
  // unsampled lines strictly below / strictly above the centre in this word
  assign lo_zeros = ~word & (full_q ? '1 : ((64'(1) << cfg_i.center_line[5:0]) - 64'(1)));
  assign hi_zeros = ~word & (full_q ? '1 : ~((64'(2) << cfg_i.center_line[5:0]) - 64'(1)));
  assign base     = BND_W'({w_q, 6'd0});
  assign lo_found = base + BND_W'(msb_idx(lo_zeros)) + BND_W'(1);
  assign hi_found = base + BND_W'(lsb_idx(hi_zeros)) - BND_W'(1);
  assign hi_end   = base + BND_W'(63);

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);
  assign off16    = {{7{cfg_i.row_offset[8]}}, cfg_i.row_offset};

  always_comb begin
    map_req_o           = '0;
    map_req_o.clr_slice = in_slice;
    map_req_o.wr_addr   = {slice_q, lw_q};
    map_req_o.wr_data   = map_rd_data_i | (64'(1) << bitpos_q);
    map_req_o.rd_addr   = {slice_q, cw};
    case (state_q)
      ST_IDLE: begin
        map_req_o.clr_en  = accept && clr_ok;
        map_req_o.rd_en   = accept && add_ok;
        map_req_o.rd_addr = {in_slice, in_data_i.line_index[6 +: WORD_W]};
      end
      ST_ADD_WR: begin
        map_req_o.wr_en = 1'b1;
      end
      ST_LO_RD, ST_HI_RD: begin
        map_req_o.rd_en = !cen_out;
      end
      ST_LO_EV: begin
        // fetch the next word down ahead of the decision
        map_req_o.rd_en   = (w_q != '0);
        map_req_o.rd_addr = {slice_q, w_q - WORD_W'(1)};
      end
      ST_HI_EV: begin
        map_req_o.rd_en   = (w_q != WORD_W'(WORDS - 1));
        map_req_o.rd_addr = {slice_q, w_q + WORD_W'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      slice_q       <= '0;
      bad_slice_q   <= 1'b0;
      err_q         <= 1'b0;
      bitpos_q      <= '0;
      lw_q          <= '0;
      w_q           <= '0;
      full_q        <= 1'b0;
      lo_q          <= '0;
      hi_q          <= '0;
      slice_valid_q <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            slice_q     <= in_slice;
            bad_slice_q <= bad_slice;
            err_q       <= bad_slice || ((in_data_i.opcode == OP_ADD) && bad_add);
            bitpos_q    <= in_data_i.line_index[5:0];
            lw_q        <= in_data_i.line_index[6 +: WORD_W];
            if (clr_ok) begin
              slice_valid_q[in_slice] <= 1'b0;
            end
            if (add_ok) begin
              slice_valid_q[in_slice] <= 1'b1;
              state_q                 <= ST_ADD_WR;
            end else begin
              state_q <= ST_LO_RD;
            end
          end
        end
        ST_ADD_WR: begin
          state_q <= ST_LO_RD;
        end
        ST_LO_RD: begin
          w_q    <= cw;
          full_q <= 1'b0;
          if (cen_out) begin
            lo_q    <= cen_ext;
            hi_q    <= cen_ext;
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_LO_EV;
          end
        end
        ST_LO_EV: begin
          if (lo_zeros != '0) begin
            lo_q    <= lo_found;
            state_q <= ST_HI_RD;
          end else if (w_q == '0) begin
            lo_q    <= '0;
            state_q <= ST_HI_RD;
          end else begin
            w_q    <= w_q - WORD_W'(1);
            full_q <= 1'b1;
          end
        end
        ST_HI_RD: begin
          w_q     <= cw;
          full_q  <= 1'b0;
          state_q <= ST_HI_EV;
        end
        ST_HI_EV: begin
          if (hi_zeros != '0) begin
            hi_q    <= hi_found;
            state_q <= ST_RESULT;
          end else if (w_q == WORD_W'(WORDS - 1)) begin
            hi_q    <= hi_end;
            state_q <= ST_RESULT;
          end else begin
            w_q    <= w_q + WORD_W'(1);
            full_q <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            out_valid_q           <= 1'b1;
            out_q.error_flag      <= err_q;
            out_q.slice_present   <= !bad_slice_q && slice_valid_q[slice_q];
            out_q.region_low      <= lo_q[7:0];
            out_q.region_high     <= hi_q[7:0];
            out_q.sufficient      <= ((hi_q - lo_q) >= BND_W'(cfg_i.min_calib_width));
            out_q.support_low     <= 16'(lo_q) + off16;
            out_q.support_high    <= 16'(hi_q) + off16;
            out_q.support_samples <= cfg_i.samples_per_line;
            state_q               <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_rmw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_req_o.wr_en |-> ($past(map_req_o.rd_en) && ($past(map_req_o.rd_addr) == map_req_o.wr_addr)))
    else $error("map write without the matching read");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ((lo_q <= cen_ext) && (hi_q >= cen_ext)))
    else $error("run bounds do not enclose the centre line");

endmodule
